[design/sbc_pkg.sv]
// Shared types and constants for the sector buffer cache controller.
// No dependencies; every other design file imports this package.
package sbc_pkg;

	localparam int POOL_SLOTS_DEF = 16;
	localparam int MAX_RESULTS    = 16;
	localparam int SECTOR_W       = 32;
	localparam int SLOT_W         = 4;

	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_ALLOC = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;
	localparam logic [1:0] ACT_FLUSH = 2'd3;

	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_CLEAN = 2'd1;
	localparam logic [1:0] ST_DIRTY = 2'd2;

	typedef struct packed {
		logic [1:0]          action;
		logic [SECTOR_W-1:0] sector;
		logic [SLOT_W-1:0]   slot;
		logic                write_through;
		logic                slot_ok;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_q_t;

endpackage

[design/sbc_front.sv]
// Front end: accepts request words, checks the slot range and queues them.
// Depends on sbc_pkg.
module sbc_front import sbc_pkg::*; #(
	parameter int PoolSlots = POOL_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_action,
	input  logic [39:0] in_data,
	output cmd_q_t      head,
	input  logic        pop
);

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       cmd_in;
	logic       push;

	always_comb begin
		cmd_in.action        = in_action;
		cmd_in.sector        = in_data[31:0];
		cmd_in.slot          = in_data[35:32];
		cmd_in.write_through = in_data[36];
		cmd_in.slot_ok       = ({1'b0, 7'(in_data[35:32])} < 8'(PoolSlots));
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

[design/sbc_back.sv]
// Back end: slot tags, states and recency ranks; search, replace, mark and flush.
// Depends on sbc_pkg.
module sbc_back import sbc_pkg::*; #(
	parameter int PoolSlots = POOL_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_q_t      head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [39:0] out_data,
	output logic        out_last
);

	localparam int RW = (PoolSlots > 1) ? $clog2(PoolSlots) : 1;
	localparam int CW = $clog2(MAX_RESULTS) + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRCH  = 3'd1;
	localparam logic [2:0] S_ACT   = 3'd2;
	localparam logic [2:0] S_WR    = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0]          state_q, state_d;
	cmd_t                cmd_q;
	logic [SECTOR_W-1:0] tag_q  [PoolSlots];
	logic [1:0]          st_q   [PoolSlots];
	logic [RW-1:0]       rank_q [PoolSlots];

	logic [RW-1:0]        order_s1 [PoolSlots];
	logic [PoolSlots-1:0] hitv_s1, freev_s1, dirtyv_s1;
	logic [RW-1:0]        order_c [PoolSlots];
	logic [PoolSlots-1:0] hitv_c, freev_c, dirtyv_c;

	logic [RW-1:0] r_q;
	logic [CW-1:0] n_q;

	logic                out_valid_q, out_last_q;
	logic [39:0]         out_data_q;
	logic                oready;

	logic [RW-1:0] hr, fr, sel_r, vic, ws, cur;
	logic          hit_any, free_any;
	logic [PoolSlots-1:0] above;
	logic          fl_last;

	logic                emit, emit_last;
	logic [SLOT_W-1:0]   e_idx;
	logic                e_hit, e_wb, e_fill;
	logic [SECTOR_W-1:0] e_wbsec;

	assign oready    = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	// rank-ordered views of the pool
	always_comb begin
		for (int r = 0; r < PoolSlots; r++) begin
			order_c[r]  = '0;
			hitv_c[r]   = 1'b0;
			freev_c[r]  = 1'b0;
			dirtyv_c[r] = 1'b0;
			for (int s = 0; s < PoolSlots; s++) begin
				if (rank_q[s] == RW'(r)) begin
					order_c[r]  = order_c[r] | RW'(s);
					hitv_c[r]   = hitv_c[r] | ((st_q[s] == ST_CLEAN || st_q[s] == ST_DIRTY)
						&& tag_q[s] == cmd_q.sector);
					freev_c[r]  = freev_c[r] | (st_q[s] != ST_CLEAN && st_q[s] != ST_DIRTY);
					dirtyv_c[r] = dirtyv_c[r] | (st_q[s] == ST_DIRTY);
				end
			end
		end
	end

	always_comb begin
		hr = '0;
		fr = '0;
		for (int r = PoolSlots - 1; r >= 0; r--)
			if (hitv_s1[r])
				hr = RW'(r);
		for (int r = 0; r < PoolSlots; r++)
			if (freev_s1[r])
				fr = RW'(r);
		hit_any  = |hitv_s1;
		free_any = |freev_s1;
		sel_r = hit_any ? hr : (free_any ? fr : RW'(PoolSlots - 1));
		vic   = order_s1[sel_r];
		ws    = RW'(cmd_q.slot);
		cur   = order_s1[r_q];
		for (int r = 0; r < PoolSlots; r++)
			above[r] = dirtyv_s1[r] && (RW'(r) > r_q);
		fl_last = (n_q == CW'(MAX_RESULTS - 1)) || !(|above);
	end

	always_comb begin
		emit      = 1'b0;
		emit_last = 1'b1;
		e_idx     = '0;
		e_hit     = 1'b0;
		e_wb      = 1'b0;
		e_wbsec   = '0;
		e_fill    = 1'b0;
		case (state_q)
			S_ACT: begin
				emit   = oready;
				e_idx  = SLOT_W'(vic);
				e_hit  = hit_any;
				if (!hit_any && st_q[vic] == ST_DIRTY) begin
					e_wb    = 1'b1;
					e_wbsec = tag_q[vic];
				end
				e_fill = !hit_any && (cmd_q.action == ACT_READ);
			end
			S_WR: begin
				emit  = oready;
				e_idx = cmd_q.slot;
				if (cmd_q.slot_ok && cmd_q.write_through) begin
					e_wb    = 1'b1;
					e_wbsec = tag_q[ws];
				end
			end
			S_FLUSH: begin
				if (dirtyv_s1 == '0) begin
					emit = oready;
				end else if (dirtyv_s1[r_q]) begin
					emit      = oready;
					emit_last = fl_last;
					e_idx     = SLOT_W'(cur);
					e_wb      = 1'b1;
					e_wbsec   = tag_q[cur];
				end
			end
			default: ;
		endcase
	end

	assign pop = head.valid && (state_q == S_IDLE || (emit && emit_last));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_SRCH: state_d = (cmd_q.action == ACT_FLUSH) ? S_FLUSH : S_ACT;
			default: begin
				if (state_q == S_IDLE || (emit && emit_last))
					state_d = S_IDLE;
			end
		endcase
		if (pop)
			state_d = (head.cmd.action == ACT_WRITE) ? S_WR : S_SRCH;
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= head.cmd;
		if (state_q == S_SRCH) begin
			order_s1 <= order_c;
			hitv_s1  <= hitv_c;
			freev_s1 <= freev_c;
		end
		if (emit) begin
			out_data_q <= {1'b0, e_fill, e_wbsec, e_wb, e_hit, e_idx};
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			r_q         <= '0;
			n_q         <= '0;
			dirtyv_s1   <= '0;
			for (int s = 0; s < PoolSlots; s++) begin
				tag_q[s]  <= '0;
				st_q[s]   <= ST_FREE;
				rank_q[s] <= RW'(s);
			end
		end else begin
			state_q <= state_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (state_q == S_SRCH) begin
				dirtyv_s1 <= dirtyv_c;
				r_q       <= '0;
				n_q       <= '0;
			end
			if (state_q == S_ACT && emit) begin
				for (int s = 0; s < PoolSlots; s++)
					if (rank_q[s] < sel_r)
						rank_q[s] <= rank_q[s] + RW'(1);
				rank_q[vic] <= '0;
				if (!hit_any) begin
					tag_q[vic] <= cmd_q.sector;
					st_q[vic]  <= (cmd_q.action == ACT_READ) ? ST_CLEAN : ST_FREE;
				end
			end
			if (state_q == S_WR && emit && cmd_q.slot_ok)
				st_q[ws] <= cmd_q.write_through ? ST_CLEAN : ST_DIRTY;
			if (state_q == S_FLUSH && dirtyv_s1 != '0) begin
				if (dirtyv_s1[r_q]) begin
					if (emit) begin
						st_q[cur]      <= ST_CLEAN;
						dirtyv_s1[r_q] <= 1'b0;
						n_q            <= n_q + CW'(1);
						r_q            <= r_q + RW'(1);
					end
				end else begin
					r_q <= r_q + RW'(1);
				end
			end
		end
	end

endmodule

[design/sector_buffer_cache_lru_top.sv]
// Top level of the sector buffer cache controller: front queue plus back engine.
// Depends on sbc_pkg, sbc_front and sbc_back.
//
// A read or allocate passes through a search state that rank-sorts the tag
// compares and an action state that picks the slot and updates recency; a
// mark-written uses a single write state. A flush rank-sorts, then scans slot
// ranks in order, writing back each dirty slot up to the last dirty one or the
// MAX_RESULTS-th result. A two-word queue sits in front of the engine, and
// results leave through a one-word output register.
module sector_buffer_cache_lru_top import sbc_pkg::*; #(
	parameter int PoolSlots = POOL_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // sector[31:0], slot[35:32], write_through[36]
	input  logic [1:0]  s_axis_tuser,  // action[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // slot_index[3:0], hit[4], writeback_needed[5],
	                                   // writeback_sector[37:6], fill_needed[38]
	output logic        m_axis_tlast
);

	cmd_q_t head;
	logic   pop;

	sbc_front #(.PoolSlots(PoolSlots)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.head      (head),
		.pop       (pop)
	);

	sbc_back #(.PoolSlots(PoolSlots)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
